[rtl/cursor_sequence_buffer_core_assert.svh]
// assertion macros used by the cursor sequence buffer core
`ifndef CURSOR_SEQUENCE_BUFFER_CORE_ASSERT_SVH
`define CURSOR_SEQUENCE_BUFFER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CSB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csb assertion failed");

// next-cycle implication, checked out of reset
`define CSB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csb assertion failed");

`endif

[rtl/csb_pkg.sv]
`timescale 1ns / 1ps
package csb_pkg;

  // default geometry
  localparam int CsbCapacityWords = 32;
  localparam int CsbWordBits      = 32;

  // fixed port widths
  localparam int KindW  = 3;
  localparam int ValueW = 32;
  localparam int CountW = 6;

  // operation codes
  typedef enum logic [KindW-1:0] {
    KIND_START   = 3'd0,
    KIND_ADVANCE = 3'd1,
    KIND_INSERT  = 3'd2,
    KIND_ATTACH  = 3'd3,
    KIND_REMOVE  = 3'd4
  } csb_kind_e;

  // per-cycle move command broadcast along the cell chain
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic load;
  } csb_ctrl_t;

endpackage

[rtl/csb_cell.sv]
`timescale 1ns / 1ps
module csb_cell import csb_pkg::*; #(
  parameter int WordBits = CsbWordBits,
  parameter int PosW     = 6,
  parameter int Idx      = 0
) (
  input  logic                clk_i,
  input  csb_ctrl_t           ctrl_i,
  input  logic [PosW-1:0]     pos_i,
  input  logic [PosW-1:0]     rd_idx_i,
  input  logic [WordBits-1:0] new_word_i,
  input  logic [WordBits-1:0] left_word_i,
  input  logic [WordBits-1:0] right_word_i,
  output logic [WordBits-1:0] word_o,
  output logic [WordBits-1:0] rd_word_o
);

  logic [WordBits-1:0] word_q;
  logic [WordBits-1:0] word_d;
  logic                at_pos;
  logic                above_pos;

  assign at_pos    = (PosW'(Idx) == pos_i);
  assign above_pos = (PosW'(Idx) > pos_i);

  // pick hold, load, take from lower neighbor or take from upper neighbor
  always_comb begin
    word_d = word_q;
    if (ctrl_i.load && at_pos) begin
      word_d = new_word_i;
    end else if (ctrl_i.shift_up && above_pos) begin
      word_d = left_word_i;
    end else if (ctrl_i.shift_down && (at_pos || above_pos)) begin
      word_d = right_word_i;
    end
  end

  // data cell, no reset needed
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

  // masked read tap for the or-reduction in the top level
  assign rd_word_o = (PosW'(Idx) == rd_idx_i) ? word_q : '0;

endmodule

[rtl/cursor_sequence_buffer_core.sv]
`timescale 1ns / 1ps
// result: valid in the cycle after the input transfer, from the output register
// throughput: one item per cycle when not stalled; ops shift the cell chain at most once
// a new item is taken while a result waits only if that result leaves in the same cycle
// reset (rst_ni low, asynchronous): count and cursor go to zero, no result pending
// cell contents are not reset; only positions below the count ever reach the result
module cursor_sequence_buffer_core import csb_pkg::*; #(
  parameter int CapacityWords = CsbCapacityWords,
  parameter int WordBits      = CsbWordBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [KindW-1:0]  in_kind_i,
  input  logic [ValueW-1:0] in_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ValueW-1:0] out_current_value_o,
  output logic              out_has_current_o,
  output logic [CountW-1:0] out_item_count_o,
  output logic [CountW-1:0] out_cursor_position_o,
  output logic              out_full_error_o
);

  `include "cursor_sequence_buffer_core_assert.svh"

  localparam int PosW = $clog2(CapacityWords + 1);

  logic [PosW-1:0] cnt_q, cnt_d;
  logic [PosW-1:0] cur_q, cur_d;
  logic            out_valid_q, out_valid_d;
  logic [ValueW-1:0] res_value_q, res_value_d;
  logic              res_has_q, res_has_d;
  logic              res_err_q, res_err_d;
  logic [PosW-1:0]   res_cnt_q, res_cur_q;

  logic            accept;
  logic            has_item;
  logic            full;
  logic [PosW-1:0] pos;
  logic [PosW-1:0] rd_idx;
  logic            use_new;
  csb_ctrl_t       ctrl;

  logic [WordBits-1:0]        new_word;
  logic [WordBits+ValueW-1:0] in_ext;
  logic [WordBits+ValueW-1:0] rd_ext;
  logic [PosW+CountW-1:0]     cnt_ext;
  logic [PosW+CountW-1:0]     cur_ext;
  logic [WordBits-1:0]        rd_word;
  logic [WordBits-1:0]        cell_word [CapacityWords];
  logic [WordBits-1:0]        cell_rd   [CapacityWords];

  // input side handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // incoming word trimmed or zero-extended to the cell width
  assign in_ext   = {{WordBits{1'b0}}, in_value_i};
  assign new_word = in_ext[WordBits-1:0];

  assign has_item = (cur_q < cnt_q);
  assign full     = (cnt_q >= PosW'(CapacityWords));

  // operation decode: cursor, count and chain command
  always_comb begin
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    pos       = cur_q;
    rd_idx    = cur_q;
    use_new   = 1'b0;
    res_err_d = 1'b0;
    ctrl      = '0;
    case (csb_kind_e'(in_kind_i))
      KIND_START: begin
        cur_d  = '0;
        rd_idx = '0;
      end
      KIND_ADVANCE: begin
        if (has_item) begin
          cur_d  = cur_q + 1'b1;
          rd_idx = cur_q + 1'b1;
        end
      end
      KIND_INSERT: begin
        if (full) begin
          res_err_d = 1'b1;
        end else begin
          pos           = has_item ? cur_q : '0;
          cur_d         = pos;
          cnt_d         = cnt_q + 1'b1;
          use_new       = 1'b1;
          ctrl.shift_up = 1'b1;
          ctrl.load     = 1'b1;
        end
      end
      KIND_ATTACH: begin
        if (full) begin
          res_err_d = 1'b1;
        end else begin
          pos           = has_item ? (cur_q + 1'b1) : cnt_q;
          cur_d         = pos;
          cnt_d         = cnt_q + 1'b1;
          use_new       = 1'b1;
          ctrl.shift_up = 1'b1;
          ctrl.load     = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (has_item) begin
          cnt_d           = cnt_q - 1'b1;
          rd_idx          = cur_q + 1'b1;
          ctrl.shift_down = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      ctrl = '0;
    end
  end

  // chain of storage cells
  for (genvar g = 0; g < CapacityWords; g++) begin : g_cell
    logic [WordBits-1:0] left_word;
    logic [WordBits-1:0] right_word;

    if (g == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_mid_l
      assign left_word = cell_word[g-1];
    end
    if (g == CapacityWords - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_mid_r
      assign right_word = cell_word[g+1];
    end

    csb_cell #(
      .WordBits (WordBits),
      .PosW     (PosW),
      .Idx      (g)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .pos_i        (pos),
      .rd_idx_i     (rd_idx),
      .new_word_i   (new_word),
      .left_word_i  (left_word),
      .right_word_i (right_word),
      .word_o       (cell_word[g]),
      .rd_word_o    (cell_rd[g])
    );
  end

  // or together the masked read taps, at most one is nonzero
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CapacityWords; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  // result word for the output register
  always_comb begin
    res_has_d   = (cur_d < cnt_d);
    rd_ext      = {{ValueW{1'b0}}, (use_new ? new_word : rd_word)};
    res_value_d = res_has_d ? rd_ext[ValueW-1:0] : '0;
  end

  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        cnt_q <= cnt_d;
        cur_q <= cur_d;
      end
    end
  end

  // result payload, loaded on each transfer in
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_value_q <= res_value_d;
      res_has_q   <= res_has_d;
      res_err_q   <= res_err_d;
      res_cnt_q   <= cnt_d;
      res_cur_q   <= cur_d;
    end
  end

  assign cnt_ext = {{CountW{1'b0}}, res_cnt_q};
  assign cur_ext = {{CountW{1'b0}}, res_cur_q};

  assign out_valid_o           = out_valid_q;
  assign out_current_value_o   = res_value_q;
  assign out_has_current_o     = res_has_q;
  assign out_item_count_o      = cnt_ext[CountW-1:0];
  assign out_cursor_position_o = cur_ext[CountW-1:0];
  assign out_full_error_o      = res_err_q;

  // checks
  `CSB_ASSERT_IMPL(a_count_bound, 1'b1, cnt_q <= PosW'(CapacityWords))
  `CSB_ASSERT_IMPL(a_cursor_bound, 1'b1, cur_q <= cnt_q)
  `CSB_ASSERT_NEXT(a_idle_holds, !accept, $stable(cnt_q) && $stable(cur_q))
  `CSB_ASSERT_NEXT(a_error_holds, accept && res_err_d, $stable(cnt_q) && res_err_q)

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;
  import csb_pkg::*;

  // unused kind codes, treated as no operation
  localparam logic [KindW-1:0] KindNopFirst = 3'd5;
  localparam logic [KindW-1:0] KindNopLast  = 3'd7;

  // operation mixes for the random runs
  localparam int MixGrow   = 0;
  localparam int MixEven   = 2;

  localparam logic [ValueW-1:0] WordMask = {ValueW{1'b1}} >> (ValueW - CsbWordBits);
  localparam int StallLimit  = 2000;
  localparam int PhaseItems  = 190;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ValueW-1:0] value;
  } seq_op_t;

  typedef struct packed {
    logic [ValueW-1:0] current_value;
    logic              has_current;
    logic [CountW-1:0] item_count;
    logic [CountW-1:0] cursor_position;
    logic              full_error;
  } seq_view_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [KindW-1:0] in_kind_i = KIND_START;
  logic [ValueW-1:0] in_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [ValueW-1:0] out_current_value_o;
  logic out_has_current_o;
  logic [CountW-1:0] out_item_count_o;
  logic [CountW-1:0] out_cursor_position_o;
  logic out_full_error_o;

  // pending stimulus, expected views and shadow buffer
  seq_op_t     pending_ops[$];
  seq_view_t   expected_views[$];
  logic [ValueW-1:0] shadow_words[$];
  int          shadow_cursor = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned ops_queued = 0;
  int unsigned ops_accepted = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  bit          op_taken = 1'b0;

  cursor_sequence_buffer_core dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .in_kind_i             (in_kind_i),
    .in_value_i            (in_value_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_current_value_o   (out_current_value_o),
    .out_has_current_o     (out_has_current_o),
    .out_item_count_o      (out_item_count_o),
    .out_cursor_position_o (out_cursor_position_o),
    .out_full_error_o      (out_full_error_o)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // apply one operation to the shadow buffer and return the view it leaves
  function automatic seq_view_t step_shadow(logic [KindW-1:0] kind, logic [ValueW-1:0] value);
    seq_view_t view;
    bit        on_item;
    on_item = shadow_cursor < shadow_words.size();
    view = '0;
    case (kind)
      KIND_START: begin
        shadow_cursor = 0;
      end
      KIND_ADVANCE: begin
        if (on_item) shadow_cursor++;
      end
      KIND_INSERT, KIND_ATTACH: begin
        if (shadow_words.size() >= CsbCapacityWords) begin
          view.full_error = 1'b1;
        end else begin
          if (kind == KIND_INSERT) begin
            if (!on_item) shadow_cursor = 0;
          end else begin
            shadow_cursor = on_item ? shadow_cursor + 1 : shadow_words.size();
          end
          shadow_words.insert(shadow_cursor, value & WordMask);
        end
      end
      KIND_REMOVE: begin
        if (on_item) shadow_words.delete(shadow_cursor);
      end
      default: ;
    endcase
    view.has_current = shadow_cursor < shadow_words.size();
    view.current_value = view.has_current ? shadow_words[shadow_cursor] : '0;
    view.item_count = CountW'(shadow_words.size());
    view.cursor_position = CountW'(shadow_cursor);
    return view;
  endfunction

  function automatic void check_field(string name, logic [ValueW-1:0] exp_v,
                                      logic [ValueW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // drive both sides at the falling edge
  always @(negedge clk_i) begin : drive_inputs
    seq_op_t next_op;
    logic    next_valid;
    next_valid = in_valid_i;
    next_op = '{in_kind_i, in_value_i};
    if (rst_ni && (!in_valid_i || op_taken)) begin
      next_valid = 1'b0;
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_op = pending_ops.pop_front();
        next_valid = 1'b1;
      end
    end
    in_valid_i <= next_valid;
    in_kind_i <= next_op.kind;
    in_value_i <= next_op.value;
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  // sample transfers at the rising edge, predict and check
  always @(posedge clk_i) begin : watch_outputs
    seq_view_t want;
    bit        moved;
    moved = 1'b0;
    op_taken = 1'b0;
    if (rst_ni) begin
      // result transfer
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (expected_views.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time,
                   out_current_value_o);
          fail_count++;
        end else begin
          want = expected_views.pop_front();
          check_field("current_value", want.current_value, out_current_value_o);
          check_field("has_current", ValueW'(want.has_current), ValueW'(out_has_current_o));
          check_field("item_count", ValueW'(want.item_count), ValueW'(out_item_count_o));
          check_field("cursor_position", ValueW'(want.cursor_position),
                      ValueW'(out_cursor_position_o));
          check_field("full_error", ValueW'(want.full_error), ValueW'(out_full_error_o));
        end
      end
      // operation transfer
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        op_taken = 1'b1;
        ops_accepted++;
        expected_views.push_back(step_shadow(in_kind_i, in_value_i));
      end
      // watchdog
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic push_op(logic [KindW-1:0] kind, logic [ValueW-1:0] value);
    pending_ops.push_back('{kind, value});
    ops_queued++;
  endtask

  function automatic logic [KindW-1:0] pick_kind(int mix);
    int unsigned cut[3][5];
    int unsigned roll;
    cut = '{'{8, 20, 55, 90, 95}, '{15, 30, 40, 50, 95}, '{15, 35, 55, 75, 95}};
    roll = $urandom_range(99);
    if (roll < cut[mix][0]) return KIND_START;
    if (roll < cut[mix][1]) return KIND_ADVANCE;
    if (roll < cut[mix][2]) return KIND_INSERT;
    if (roll < cut[mix][3]) return KIND_ATTACH;
    if (roll < cut[mix][4]) return KIND_REMOVE;
    return KindW'($urandom_range(KindNopLast, KindNopFirst));
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // random runs that grow, shrink or churn the buffer, each mix picked at random
  task automatic push_random(int unsigned count);
    int mix;
    int unsigned run_len;
    while (count > 0) begin
      mix = $urandom_range(MixEven, MixGrow);
      run_len = (mix == MixGrow) ? $urandom_range(70, 30) : $urandom_range(50, 10);
      if (run_len > count) run_len = count;
      repeat (run_len) push_op(pick_kind(mix), pick_value());
      count -= run_len;
    end
  endtask

  task automatic push_directed();
    push_op(KIND_START, '0);
    push_op(KIND_ADVANCE, '0);           // advance on empty buffer
    push_op(KIND_REMOVE, '1);            // remove with nothing current
    push_op(KIND_INSERT, '0);            // insert into empty buffer
    push_op(KIND_ATTACH, '1);
    push_op(KIND_ADVANCE, '0);           // cursor runs off the end
    push_op(KIND_ADVANCE, '0);           // advance with nothing current
    push_op(KIND_INSERT, 32'h5a5a5a5a);  // insert with nothing current goes to front
    push_op(KIND_ADVANCE, '0);
    push_op(KIND_ATTACH, 32'ha5a5a5a5);
    push_op(KIND_ADVANCE, '0);
    push_op(KIND_ADVANCE, '0);
    push_op(KIND_ATTACH, 32'h12345678);  // attach with nothing current goes to end
    push_op(KIND_START, '1);
    push_op(KIND_REMOVE, '0);
    push_op(KindNopFirst, '1);
    push_op(KindW'(KindNopFirst + 1), '1);
    push_op(KindNopLast, '1);
    push_op(KIND_INSERT, 32'h80000000);
    push_op(KIND_ATTACH, 32'h00000001);
    push_op(KIND_ADVANCE, '0);
    push_op(KIND_REMOVE, '0);
    push_op(KIND_START, '0);
    push_op(KIND_REMOVE, '0);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (ops_accepted != ops_queued || expected_views.size() != 0);
  endtask

  // stimulus phases, each drained before the next
  initial begin : run_phases
    int unsigned idle_plan[4];
    int unsigned stall_plan[4];
    idle_plan = '{0, 82, 0, 36};
    stall_plan = '{0, 0, 82, 36};
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    for (int p = 0; p < 4; p++) begin
      @(posedge clk_i);
      send_idle_pct = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      if (p == 0) push_directed();
      push_random(PhaseItems);
      wait_drained();
    end
    repeat (5) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[cursor_sequence_buffer_core.f]
+incdir+rtl
rtl/csb_pkg.sv
rtl/csb_cell.sv
rtl/cursor_sequence_buffer_core.sv
bench/tb.sv
